>>> src/tah_pkg.sv
// Shared types, constants and tables for the triplet angle histogram.
// Used by the top module and tah_angle; depends on nothing.
`timescale 1ns / 1ps
package tah_pkg;

  localparam int MaxBinsDef   = 512;
  localparam int CountBitsDef = 32;
  localparam int CoordW       = 24;
  localparam int DiffW        = 25;
  localparam int BoxW         = 23;
  localparam int CutW         = 19;
  localparam int BwW          = 16;
  localparam int BinCntW      = 10;
  localparam int BinNumW      = 10;
  localparam int BinW         = 17;
  localparam int CfgIdxW      = 3;
  localparam int CfgDataW     = 23;
  localparam int OutValW      = 32;
  localparam int CordicSteps  = 20;
  localparam int AtanW        = 22;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgBoxX  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgBoxY  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgBoxZ  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgInner = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgOuter = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgBinW  = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgBinN  = 3'd6;

  typedef enum logic [1:0] {
    REQ_ACC   = 2'd0,
    REQ_READ  = 2'd1,
    REQ_CLEAR = 2'd2
  } req_e;

  typedef logic signed [CoordW-1:0] coord_t;

  typedef struct packed {
    logic [BoxW-1:0]    box_x;
    logic [BoxW-1:0]    box_y;
    logic [BoxW-1:0]    box_z;
    logic [CutW-1:0]    inner;
    logic [CutW-1:0]    outer;
    logic [BwW-1:0]     bin_w;
    logic [BinCntW-1:0] bin_n;
  } cfg_t;

  typedef struct packed {
    logic            ok;
    logic [BinW-1:0] bin;
  } ang_res_t;

  // atan(2^-i) in degrees * 65536, rounded
  function automatic logic [AtanW-1:0] atan_deg(input logic [4:0] i);
    logic [AtanW-1:0] a;
    case (i)
      5'd0:  a = 22'd2949120;
      5'd1:  a = 22'd1740967;
      5'd2:  a = 22'd919879;
      5'd3:  a = 22'd466945;
      5'd4:  a = 22'd234379;
      5'd5:  a = 22'd117304;
      5'd6:  a = 22'd58666;
      5'd7:  a = 22'd29335;
      5'd8:  a = 22'd14668;
      5'd9:  a = 22'd7334;
      5'd10: a = 22'd3667;
      5'd11: a = 22'd1833;
      5'd12: a = 22'd917;
      5'd13: a = 22'd458;
      5'd14: a = 22'd229;
      5'd15: a = 22'd115;
      5'd16: a = 22'd57;
      5'd17: a = 22'd29;
      5'd18: a = 22'd14;
      5'd19: a = 22'd7;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

>>> src/triplet_angle_histogram_top.sv
// An accumulate passes through the remainder, fixup, multiply, check, normalize, square,
// isqrt, CORDIC, divide and done steps, then the histogram read and write; a skipped
// triplet leaves after the check and takes only the write step. A read or read-clear takes
// the read and write steps, a bad bin or unknown request only the write step. One word in
// flight; the write step waits while the output is stalled. After reset the histogram RAM
// is swept to zero and no input word is taken. Depends on tah_pkg, tah_ram and tah_angle.
`timescale 1ns / 1ps
module triplet_angle_histogram_top #(
  parameter int MAX_BINS   = tah_pkg::MaxBinsDef,
  parameter int COUNT_BITS = tah_pkg::CountBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tah_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [tah_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    req_type_i,
  input  logic signed [23:0]            centre_x_i,
  input  logic signed [23:0]            centre_y_i,
  input  logic signed [23:0]            centre_z_i,
  input  logic signed [23:0]            first_x_i,
  input  logic signed [23:0]            first_y_i,
  input  logic signed [23:0]            first_z_i,
  input  logic signed [23:0]            second_x_i,
  input  logic signed [23:0]            second_y_i,
  input  logic signed [23:0]            second_z_i,
  input  logic [9:0]                    read_bin_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          counted_o,
  output logic [9:0]                    bin_number_o,
  output logic [31:0]                   bin_value_o
);
  import tah_pkg::*;

  localparam int AW = $clog2(MAX_BINS);
  localparam int VB = (COUNT_BITS > OutValW) ? COUNT_BITS : OutValW;

  typedef enum logic [2:0] {ST_CLEAR, ST_IDLE, ST_CALC, ST_READ, ST_WRITE} state_e;

  state_e state_q;
  cfg_t cfg_q;
  req_e req_q;
  logic [AW-1:0] addr_q, clr_q;
  logic [BinNumW-1:0] num_q;
  logic hit_q;
  logic out_valid_q, counted_q;
  logic [BinNumW-1:0] number_q;
  logic [OutValW-1:0] value_q;
  logic accept, out_free, ang_done;
  ang_res_t ang_res;
  logic ram_we, ram_re;
  logic [AW-1:0] ram_waddr;
  logic [COUNT_BITS-1:0] ram_wdata, ram_rdata, cnt_inc, new_val;
  logic [VB-1:0] wide_val;
  logic rd_ok, bin_ok;

  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign rd_ok    = (read_bin_i != '0) && (13'(read_bin_i) <= 13'(MAX_BINS));
  assign bin_ok   = ang_res.ok && (ang_res.bin <= {7'b0, cfg_q.bin_n}) &&
                    (ang_res.bin <= BinW'(MAX_BINS));

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{box_x: 23'd409600, box_y: 23'd409600, box_z: 23'd409600,
                 inner: 19'd0, outer: 19'd12288, bin_w: 16'd128, bin_n: 10'd360};
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgBoxX:  cfg_q.box_x <= cfg_data_i;
        CfgBoxY:  cfg_q.box_y <= cfg_data_i;
        CfgBoxZ:  cfg_q.box_z <= cfg_data_i;
        CfgInner: cfg_q.inner <= cfg_data_i[CutW-1:0];
        CfgOuter: cfg_q.outer <= cfg_data_i[CutW-1:0];
        CfgBinW:  cfg_q.bin_w <= cfg_data_i[BwW-1:0];
        CfgBinN:  cfg_q.bin_n <= cfg_data_i[BinCntW-1:0];
        default: ;
      endcase
    end
  end

  tah_angle u_angle (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (accept && (req_type_i == REQ_ACC)),
    .cfg_i    (cfg_q),
    .centre_i ({centre_z_i, centre_y_i, centre_x_i}),
    .first_i  ({first_z_i, first_y_i, first_x_i}),
    .second_i ({second_z_i, second_y_i, second_x_i}),
    .done_o   (ang_done),
    .res_o    (ang_res)
  );

  // saturating increment and result value
  assign cnt_inc  = (ram_rdata == '1) ? ram_rdata : ram_rdata + 1'b1;
  assign new_val  = !hit_q ? '0 : ((req_q == REQ_ACC) ? cnt_inc : ram_rdata);
  assign wide_val = VB'(new_val);

  // histogram port: sweep after reset, otherwise read, then write back for accumulate and clear
  always_comb begin
    ram_re    = (state_q == ST_READ);
    ram_we    = 1'b0;
    ram_waddr = addr_q;
    ram_wdata = '0;
    if (state_q == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_q;
    end else if (state_q == ST_WRITE && out_free && hit_q) begin
      ram_we    = (req_q == REQ_ACC) || (req_q == REQ_CLEAR);
      ram_wdata = (req_q == REQ_ACC) ? cnt_inc : '0;
    end
  end

  tah_ram #(
    .Width (COUNT_BITS),
    .Depth (MAX_BINS)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (addr_q),
    .rdata_o (ram_rdata)
  );

  // control sequence and output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && (state_q != ST_WRITE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == AW'(MAX_BINS - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            req_q  <= req_e'(req_type_i);
            addr_q <= AW'(read_bin_i - 10'd1);
            num_q  <= read_bin_i;
            case (req_type_i)
              REQ_ACC: begin
                state_q <= ST_CALC;
              end
              REQ_READ, REQ_CLEAR: begin
                hit_q   <= rd_ok;
                state_q <= rd_ok ? ST_READ : ST_WRITE;
              end
              default: begin
                hit_q   <= 1'b0;
                state_q <= ST_WRITE;
              end
            endcase
          end
        end
        ST_CALC: begin
          if (ang_done) begin
            hit_q   <= bin_ok;
            addr_q  <= AW'(ang_res.bin - 17'd1);
            num_q   <= ang_res.bin[BinNumW-1:0];
            state_q <= bin_ok ? ST_READ : ST_WRITE;
          end
        end
        ST_READ: begin
          state_q <= ST_WRITE;
        end
        ST_WRITE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            counted_q   <= hit_q && (req_q == REQ_ACC);
            number_q    <= hit_q ? num_q : '0;
            value_q     <= (wide_val > VB'(33'h0_FFFF_FFFF)) ? '1 : wide_val[OutValW-1:0];
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o   = (state_q != ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign counted_o    = counted_q;
  assign bin_number_o = number_q;
  assign bin_value_o  = value_q;

endmodule

>>> src/tah_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// Standalone; no package use.
`timescale 1ns / 1ps
module tah_ram #(
  parameter int Width = 32,
  parameter int Depth = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read, held between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/tah_angle.sv
// Sequential angle unit: minimum image, distance test, cross/dot, isqrt,
// CORDIC atan2 and bin division. Depends on tah_pkg.
`timescale 1ns / 1ps
module tah_angle (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  tah_pkg::cfg_t          cfg_i,
  input  tah_pkg::coord_t [2:0]  centre_i,
  input  tah_pkg::coord_t [2:0]  first_i,
  input  tah_pkg::coord_t [2:0]  second_i,
  output logic                   done_o,
  output tah_pkg::ang_res_t      res_o
);
  import tah_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_WRAP, S_FIX, S_MUL, S_CHK, S_NORM, S_SQ, S_SQRT, S_CORD, S_DIV, S_DONE
  } state_e;

  // operand codes for the shared multiplier
  localparam logic [2:0] VP0 = 3'd0, VP1 = 3'd1, VP2 = 3'd2;
  localparam logic [2:0] VN0 = 3'd3, VN1 = 3'd4, VN2 = 3'd5;
  localparam logic [2:0] VIN = 3'd6, VOUT = 3'd7;
  // accumulator indexes
  localparam logic [2:0] AD2 = 3'd0, ADOT = 3'd1, AC0 = 3'd2, AC1 = 3'd3, AC2 = 3'd4;
  localparam logic [2:0] AIN = 3'd5, AOUT = 3'd6;
  localparam logic signed [31:0] Deg90  = 32'sd5898240;
  localparam logic signed [31:0] Deg180 = 32'sd11796480;

  state_e state_q;
  logic [4:0] cnt_q;
  logic signed [DiffW-1:0] d_q [6];
  logic [DiffW-1:0] wm_q [6];
  logic [BoxW-1:0] wr_q [6];
  logic [BoxW-1:0] wr_d [6];
  logic signed [DiffW-1:0] fix_v [6];
  logic [BoxW-1:0] len [6];
  logic signed [61:0] prod_q;
  logic [2:0] tgt_q;
  logic sub_q, pv_q;
  logic signed [51:0] acc_q [7];
  logic [50:0] mg_q [4];
  logic dpos_q;
  logic [61:0] sum_q;
  logic [63:0] v_q, r_q, bit_q;
  logic [63:0] rb_sum, r_nx;
  logic signed [35:0] x_q, y_q, xs, ys;
  logic signed [31:0] z_q, zc;
  logic [15:0] dv_q, rem_q;
  logic [16:0] dt;
  ang_res_t res_q;
  logic [2:0] opa, opb, tgt;
  logic sub;
  logic signed [30:0] mul_a, mul_b;
  logic cond, big;

  function automatic logic signed [30:0] vsel(input logic [2:0] c,
                                              input logic signed [DiffW-1:0] p0,
                                              input logic signed [DiffW-1:0] p1,
                                              input logic signed [DiffW-1:0] p2,
                                              input logic signed [DiffW-1:0] n0,
                                              input logic signed [DiffW-1:0] n1,
                                              input logic signed [DiffW-1:0] n2,
                                              input logic [CutW-1:0] ci,
                                              input logic [CutW-1:0] co);
    logic signed [30:0] v;
    case (c)
      VP0:  v = 31'(p0);
      VP1:  v = 31'(p1);
      VP2:  v = 31'(p2);
      VN0:  v = 31'(n0);
      VN1:  v = 31'(n1);
      VN2:  v = 31'(n2);
      VIN:  v = $signed({12'b0, ci});
      default: v = $signed({12'b0, co});
    endcase
    return v;
  endfunction

  // lane lengths: lanes 0..2 pair vector, 3..5 neighbor vector
  assign len[0] = cfg_i.box_x;
  assign len[1] = cfg_i.box_y;
  assign len[2] = cfg_i.box_z;
  assign len[3] = cfg_i.box_x;
  assign len[4] = cfg_i.box_y;
  assign len[5] = cfg_i.box_z;

  // one remainder bit per lane per cycle, then the minimum image fixup
  always_comb begin
    for (int j = 0; j < 6; j++) begin
      logic [BoxW:0] t;
      logic [BoxW-1:0] rr;
      t = {wr_q[j], wm_q[j][DiffW-1]};
      if (t >= {1'b0, len[j]}) begin
        wr_d[j] = BoxW'(t - {1'b0, len[j]});
      end else begin
        wr_d[j] = t[BoxW-1:0];
      end
      rr = (d_q[j][DiffW-1] && wr_q[j] != '0) ? len[j] - wr_q[j] : wr_q[j];
      if (len[j] == '0) begin
        fix_v[j] = d_q[j];
      end else if ({rr, 1'b0} >= {1'b0, len[j]}) begin
        fix_v[j] = $signed({2'b0, rr}) - $signed({2'b0, len[j]});
      end else begin
        fix_v[j] = $signed({2'b0, rr});
      end
    end
  end

  // product schedule for the shared multiplier
  always_comb begin
    opa = VN0; opb = VN0; tgt = AD2; sub = 1'b0;
    case (cnt_q[3:0])
      4'd0:  begin opa = VN0; opb = VN0; tgt = AD2; end
      4'd1:  begin opa = VN1; opb = VN1; tgt = AD2; end
      4'd2:  begin opa = VN2; opb = VN2; tgt = AD2; end
      4'd3:  begin opa = VP0; opb = VN0; tgt = ADOT; end
      4'd4:  begin opa = VP1; opb = VN1; tgt = ADOT; end
      4'd5:  begin opa = VP2; opb = VN2; tgt = ADOT; end
      4'd6:  begin opa = VP1; opb = VN2; tgt = AC0; end
      4'd7:  begin opa = VP2; opb = VN1; tgt = AC0; sub = 1'b1; end
      4'd8:  begin opa = VP2; opb = VN0; tgt = AC1; end
      4'd9:  begin opa = VP0; opb = VN2; tgt = AC1; sub = 1'b1; end
      4'd10: begin opa = VP0; opb = VN1; tgt = AC2; end
      4'd11: begin opa = VP1; opb = VN0; tgt = AC2; sub = 1'b1; end
      4'd12: begin opa = VIN; opb = VIN; tgt = AIN; end
      4'd13: begin opa = VOUT; opb = VOUT; tgt = AOUT; end
      default: begin opa = VN0; opb = VN0; tgt = AD2; end
    endcase
    if (state_q == S_SQ) begin
      mul_a = $signed({1'b0, mg_q[cnt_q[1:0]][29:0]});
      mul_b = mul_a;
    end else begin
      mul_a = vsel(opa, d_q[0], d_q[1], d_q[2], d_q[3], d_q[4], d_q[5],
                   cfg_i.inner, cfg_i.outer);
      mul_b = vsel(opb, d_q[0], d_q[1], d_q[2], d_q[3], d_q[4], d_q[5],
                   cfg_i.inner, cfg_i.outer);
    end
  end

  // distance window, nonzero vectors, nonzero bin width
  assign cond = (acc_q[AIN] <= acc_q[AD2]) && (acc_q[AD2] < acc_q[AOUT]) &&
                (acc_q[AD2] != '0) &&
                ((d_q[0] != '0) || (d_q[1] != '0) || (d_q[2] != '0)) &&
                (cfg_i.bin_w != '0);
  assign big = (mg_q[0][50:30] != '0) || (mg_q[1][50:30] != '0) ||
               (mg_q[2][50:30] != '0) || (mg_q[3][50:30] != '0);

  // isqrt step, CORDIC shifts, clamp and divide step
  assign rb_sum = r_q + bit_q;
  assign r_nx   = (v_q >= rb_sum) ? ((r_q >> 1) + bit_q) : (r_q >> 1);
  assign xs     = x_q >>> cnt_q;
  assign ys     = y_q >>> cnt_q;
  assign zc     = (z_q < 0) ? 32'sd0 : ((z_q > Deg180) ? Deg180 : z_q);
  assign dt     = {rem_q, dv_q[15]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      pv_q    <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            for (int k = 0; k < 3; k++) begin
              d_q[k]     <= DiffW'($signed(second_i[k])) - DiffW'($signed(first_i[k]));
              d_q[k + 3] <= DiffW'($signed(first_i[k])) - DiffW'($signed(centre_i[k]));
            end
            cnt_q   <= '0;
            state_q <= S_WRAP;
          end
        end
        S_WRAP: begin
          // load magnitudes on the first cycle, then shift in one bit per cycle
          if (cnt_q == '0) begin
            for (int j = 0; j < 6; j++) begin
              wm_q[j] <= d_q[j][DiffW-1] ? DiffW'(-d_q[j]) : DiffW'(d_q[j]);
              wr_q[j] <= '0;
            end
            cnt_q <= cnt_q + 5'd1;
          end else begin
            for (int j = 0; j < 6; j++) begin
              wr_q[j] <= wr_d[j];
              wm_q[j] <= {wm_q[j][DiffW-2:0], 1'b0};
            end
            if (cnt_q == 5'(DiffW)) begin
              state_q <= S_FIX;
            end
            cnt_q <= cnt_q + 5'd1;
          end
        end
        S_FIX: begin
          for (int j = 0; j < 6; j++) begin
            d_q[j] <= fix_v[j];
          end
          for (int a = 0; a < 7; a++) begin
            acc_q[a] <= '0;
          end
          cnt_q   <= '0;
          pv_q    <= 1'b0;
          state_q <= S_MUL;
        end
        S_MUL: begin
          if (pv_q) begin
            acc_q[tgt_q] <= sub_q ? acc_q[tgt_q] - $signed(prod_q[51:0])
                                  : acc_q[tgt_q] + $signed(prod_q[51:0]);
          end
          prod_q <= mul_a * mul_b;
          tgt_q  <= tgt;
          sub_q  <= sub;
          pv_q   <= (cnt_q < 5'd14);
          cnt_q  <= cnt_q + 5'd1;
          if (cnt_q == 5'd14) begin
            state_q <= S_CHK;
          end
        end
        S_CHK: begin
          mg_q[0] <= acc_q[AC0][51] ? 51'(-acc_q[AC0]) : 51'(acc_q[AC0]);
          mg_q[1] <= acc_q[AC1][51] ? 51'(-acc_q[AC1]) : 51'(acc_q[AC1]);
          mg_q[2] <= acc_q[AC2][51] ? 51'(-acc_q[AC2]) : 51'(acc_q[AC2]);
          mg_q[3] <= acc_q[ADOT][51] ? 51'(-acc_q[ADOT]) : 51'(acc_q[ADOT]);
          dpos_q  <= !acc_q[ADOT][51];
          if (cond) begin
            state_q <= S_NORM;
          end else begin
            res_q   <= '{ok: 1'b0, bin: '0};
            state_q <= S_DONE;
          end
        end
        S_NORM: begin
          // common right shift until all fit in 30 bits
          if (big) begin
            for (int j = 0; j < 4; j++) begin
              mg_q[j] <= mg_q[j] >> 1;
            end
          end else begin
            cnt_q   <= '0;
            pv_q    <= 1'b0;
            sum_q   <= '0;
            state_q <= S_SQ;
          end
        end
        S_SQ: begin
          if (pv_q) begin
            sum_q <= sum_q + 62'(prod_q);
          end
          prod_q <= mul_a * mul_b;
          pv_q   <= (cnt_q < 5'd3);
          cnt_q  <= cnt_q + 5'd1;
          if (cnt_q == 5'd3) begin
            state_q <= S_SQRT;
            v_q     <= {2'b0, sum_q + 62'(prod_q)};
            r_q     <= '0;
            bit_q   <= 64'd1 << 62;
          end
        end
        S_SQRT: begin
          if (v_q >= rb_sum) begin
            v_q <= v_q - rb_sum;
          end
          r_q   <= r_nx;
          bit_q <= bit_q >> 2;
          if (bit_q == 64'd1) begin
            cnt_q <= '0;
            if (dpos_q) begin
              x_q <= $signed({5'b0, mg_q[3][30:0]});
              y_q <= $signed({5'b0, r_nx[30:0]});
              z_q <= '0;
            end else begin
              x_q <= $signed({5'b0, r_nx[30:0]});
              y_q <= $signed({5'b0, mg_q[3][30:0]});
              z_q <= Deg90;
            end
            state_q <= S_CORD;
          end
        end
        S_CORD: begin
          if (y_q > 0) begin
            x_q <= x_q + ys;
            y_q <= y_q - xs;
            z_q <= z_q + $signed({10'b0, atan_deg(cnt_q)});
          end else begin
            x_q <= x_q - ys;
            y_q <= y_q + xs;
            z_q <= z_q - $signed({10'b0, atan_deg(cnt_q)});
          end
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'(CordicSteps - 1)) begin
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          // first cycle loads the angle, then one quotient bit per cycle
          if (cnt_q == 5'(CordicSteps)) begin
            dv_q  <= zc[23:8];
            rem_q <= '0;
            cnt_q <= '0;
          end else begin
            if (dt >= {1'b0, cfg_i.bin_w}) begin
              rem_q <= 16'(dt - {1'b0, cfg_i.bin_w});
              dv_q  <= {dv_q[14:0], 1'b1};
            end else begin
              rem_q <= dt[15:0];
              dv_q  <= {dv_q[14:0], 1'b0};
            end
            cnt_q <= cnt_q + 5'd1;
            if (cnt_q == 5'd15) begin
              res_q   <= '{ok: 1'b1, bin: {1'b0, dv_q[14:0], (dt >= {1'b0, cfg_i.bin_w})} + 17'd1};
              state_q <= S_DONE;
            end
          end
        end
        S_DONE: begin
          state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign done_o = (state_q == S_DONE);
  assign res_o  = res_q;

endmodule
